// ===== rtl/dual_pool_buffer_allocator_core_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the dual pool buffer allocator
// Clocked assertions with the block's own clock and reset.
// ---------------------------------------------------------------------------
`ifndef DUAL_POOL_BUFFER_ALLOCATOR_CORE_DEFINES_SVH
`define DUAL_POOL_BUFFER_ALLOCATOR_CORE_DEFINES_SVH

// Same-cycle property, checked on every edge outside reset.
`define DPBA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Property whose consequent is checked in the cycle after the antecedent.
`define DPBA_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

// ===== rtl/dpba_pkg.sv =====
// ---------------------------------------------------------------------------
// dpba_pkg
// Shared types and constants of the dual pool buffer allocator.
// ---------------------------------------------------------------------------
package dpba_pkg;

	localparam int TX_DEPTH_DFLT = 16;
	localparam int RX_DEPTH_DFLT = 16;

	localparam int OP_W     = 2;
	localparam int ID_W     = 5;
	localparam int CNT_W    = 5;
	localparam int STATUS_W = 2;
	localparam int ID_SPACE = 1 << ID_W;

	typedef enum logic [OP_W-1:0] {
		OP_ALLOC_TX = 2'd0,
		OP_ALLOC_RX = 2'd1,
		OP_RELEASE  = 2'd2
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK         = 2'd0,
		ST_EMPTY      = 2'd1,
		ST_NOT_IN_USE = 2'd2
	} status_t;

	// requests into a free stack
	typedef struct packed {
		logic pop;
		logic push;
	} stk_ctrl_t;

	// free stack occupancy flags
	typedef struct packed {
		logic empty;
		logic full;
	} stk_stat_t;

endpackage

// ===== rtl/dpba_free_stack.sv =====
// ---------------------------------------------------------------------------
// dpba_free_stack
// LIFO free list of local buffer indices with a registered top entry.
// ---------------------------------------------------------------------------
`include "dual_pool_buffer_allocator_core_defines.svh"

module dpba_free_stack
	import dpba_pkg::*;
#(
	parameter int DEPTH = TX_DEPTH_DFLT,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int LW = $clog2(DEPTH + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  stk_ctrl_t     ctrl,
	input  logic [AW-1:0] push_data,
	output stk_stat_t     stat,
	output logic [LW-1:0] level_next,
	output logic [AW-1:0] top
);

	logic [AW-1:0] mem [DEPTH];
	logic [LW-1:0] level_q;
	logic [LW-1:0] low_q;   // lowest level reached since reset
	logic [LW-1:0] low_next;
	logic [AW-1:0] top_q;
	logic [AW-1:0] rd_addr;

	always_comb begin
		level_next = level_q;
		if (ctrl.pop) begin
			level_next = level_q - LW'(1);
		end else if (ctrl.push) begin
			level_next = level_q + LW'(1);
		end
		low_next = (level_next < low_q) ? level_next : low_q;
		rd_addr  = AW'(level_next - LW'(1));
	end

	assign stat.empty = (level_q == '0);
	assign stat.full  = (level_q == LW'(DEPTH));
	assign top        = top_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= LW'(DEPTH);
			low_q   <= LW'(DEPTH);
		end else if (ctrl.pop || ctrl.push) begin
			level_q <= level_next;
			low_q   <= low_next;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			mem[level_q[AW-1:0]] <= push_data;
		end
	end

	// Entries below the low-water mark were never written and still hold
	// their own index; bypass the pushed value straight into the top.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q <= AW'(DEPTH - 1);
		end else if (ctrl.push) begin
			top_q <= push_data;
		end else if (ctrl.pop) begin
			if (LW'(rd_addr) < low_next) begin
				top_q <= rd_addr;
			end else begin
				top_q <= mem[rd_addr];
			end
		end
	end

	`DPBA_ASSERT(a_level_range, level_q <= LW'(DEPTH), "free level beyond depth")
	`DPBA_ASSERT(a_low_below_level, low_q <= level_q, "low-water mark above level")
	`DPBA_ASSERT(a_pop_nonempty, !(ctrl.pop && (stat.empty || ctrl.push)), "bad pop")
	`DPBA_ASSERT_NEXT(a_push_top, ctrl.push && !stat.full, top_q == $past(push_data), "top lost push")

endmodule

// ===== rtl/dual_pool_buffer_allocator_core.sv =====
// ---------------------------------------------------------------------------
// dual_pool_buffer_allocator_core
// Transmit and receive buffer pools kept as LIFO free lists.
// ---------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_ stream: s_tuser carries the operation
//   (allocate transmit, allocate receive, release), s_tdata the buffer
//   number to release. Every request gives exactly one result beat on the
//   m_ stream: m_tuser carries the status, m_tdata the granted buffer and
//   both free counts after the request.
//   One request is served every cycle while the receiver takes result
//   beats. The rate is set by the single pop or push per pool per cycle,
//   with the next top entry read into a register.
//   After reset both pools are full and no buffer is in use.
//   When the receiver stalls, the result register holds its beat and the
//   input register takes one more request; s_tready then drops until the
//   result beat is taken.
// ---------------------------------------------------------------------------
module dual_pool_buffer_allocator_core
	import dpba_pkg::*;
#(
	parameter int TX_POOL_DEPTH = TX_DEPTH_DFLT,
	parameter int RX_POOL_DEPTH = RX_DEPTH_DFLT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,    // [4:0] buffer_id, [7:5] zero
	input  logic [1:0]  s_tuser,    // [1:0] operation
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,    // [4:0] granted_id, [9:5] tx_free_count,
	                                // [14:10] rx_free_count, [15] zero
	output logic [1:0]  m_tuser     // [1:0] status
);

	localparam int TX_AW = (TX_POOL_DEPTH > 1) ? $clog2(TX_POOL_DEPTH) : 1;
	localparam int TX_LW = $clog2(TX_POOL_DEPTH + 1);
	localparam int RX_AW = (RX_POOL_DEPTH > 1) ? $clog2(RX_POOL_DEPTH) : 1;
	localparam int RX_LW = $clog2(RX_POOL_DEPTH + 1);
	localparam int ALL_BUFFERS = TX_POOL_DEPTH + RX_POOL_DEPTH;

	// input stage
	logic            vld_s1;
	op_t             op_s1;
	logic [ID_W-1:0] id_s1;

	// result register
	logic             out_vld_q;
	status_t          status_q;
	logic [ID_W-1:0]  grant_q;
	logic [CNT_W-1:0] tx_cnt_q;
	logic [CNT_W-1:0] rx_cnt_q;

	logic [ID_SPACE-1:0] in_use_q;

	stk_ctrl_t        tx_ctrl, rx_ctrl;
	stk_stat_t        tx_stat, rx_stat;
	logic [TX_AW-1:0] tx_push_data, tx_top;
	logic [RX_AW-1:0] rx_push_data, rx_top;
	logic [TX_LW-1:0] tx_level_next;
	logic [RX_LW-1:0] rx_level_next;

	logic            fire;
	status_t         status_c;
	logic [ID_W-1:0] grant_c;
	logic            set_mark, clr_mark;
	logic [ID_W-1:0] set_idx;
	int              rx_global;

	assign fire     = vld_s1 && (!out_vld_q || m_tready);
	assign s_tready = !vld_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			vld_s1 <= 1'b1;
		end else if (fire) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1 <= op_t'(s_tuser);
			id_s1 <= s_tdata[ID_W-1:0];
		end
	end

	assign rx_global = TX_POOL_DEPTH + int'(rx_top);

	always_comb begin
		status_c     = ST_OK;
		grant_c      = '0;
		tx_ctrl      = '0;
		rx_ctrl      = '0;
		set_mark     = 1'b0;
		clr_mark     = 1'b0;
		set_idx      = '0;
		tx_push_data = TX_AW'(id_s1);
		rx_push_data = RX_AW'(int'(id_s1) - TX_POOL_DEPTH);
		unique case (op_s1)
			OP_ALLOC_TX: begin
				if (tx_stat.empty) begin
					status_c = ST_EMPTY;
				end else begin
					tx_ctrl.pop = fire;
					grant_c     = ID_W'(tx_top);
					set_idx     = ID_W'(tx_top);
					set_mark    = fire && (int'(tx_top) < ID_SPACE);
				end
			end
			OP_ALLOC_RX: begin
				if (rx_stat.empty) begin
					status_c = ST_EMPTY;
				end else begin
					rx_ctrl.pop = fire;
					grant_c     = ID_W'(rx_global);
					set_idx     = ID_W'(rx_global);
					set_mark    = fire && (rx_global < ID_SPACE);
				end
			end
			OP_RELEASE: begin
				if ((int'(id_s1) >= ALL_BUFFERS) || !in_use_q[id_s1]) begin
					status_c = ST_NOT_IN_USE;
				end else begin
					clr_mark = fire;
					// skip the push on a full stack, still clear the mark
					if (int'(id_s1) < TX_POOL_DEPTH) begin
						tx_ctrl.push = fire && !tx_stat.full;
					end else begin
						rx_ctrl.push = fire && !rx_stat.full;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q <= '0;
		end else begin
			if (set_mark) begin
				in_use_q[set_idx] <= 1'b1;
			end
			if (clr_mark) begin
				in_use_q[id_s1] <= 1'b0;
			end
		end
	end

	dpba_free_stack #(
		.DEPTH(TX_POOL_DEPTH)
	) u_tx_stack (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (tx_ctrl),
		.push_data (tx_push_data),
		.stat      (tx_stat),
		.level_next(tx_level_next),
		.top       (tx_top)
	);

	dpba_free_stack #(
		.DEPTH(RX_POOL_DEPTH)
	) u_rx_stack (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (rx_ctrl),
		.push_data (rx_push_data),
		.stat      (rx_stat),
		.level_next(rx_level_next),
		.top       (rx_top)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (fire) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	// hold the result beat until taken
	always_ff @(posedge clk) begin
		if (fire) begin
			status_q <= status_c;
			grant_q  <= grant_c;
			tx_cnt_q <= CNT_W'(tx_level_next);
			rx_cnt_q <= CNT_W'(rx_level_next);
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tuser  = status_q;
	assign m_tdata  = {1'b0, rx_cnt_q, tx_cnt_q, grant_q};

endmodule
